// ----- hw/rtl/swstat_pkg.sv -----
// Shared sizes, widths and controller state encoding for the sliding-window
// statistics unit. No dependencies; imported by every module of the block but swstat_ram.
package swstat_pkg;

   // Window geometry.
   localparam int WINDOW   = 64;
   localparam int IDX_W    = $clog2(WINDOW);
   localparam int CNT_W    = $clog2(WINDOW + 1);

   // Data widths.
   localparam int SAMPLE_W = 32;
   localparam int SUM_W    = SAMPLE_W + IDX_W;
   localparam int STEP_W   = $clog2(SUM_W + 1);
   localparam int COUNT_W  = 7;

   // Result word: valid_count, window_mean, window_min, window_max, zero pad.
   localparam int RSP_USED_W = COUNT_W + 3 * SAMPLE_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_START,
      ST_WAIT,
      ST_PUSH
   } state_type;

endpackage

// ----- hw/rtl/swstat_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; sized by its WIDTH and DEPTH parameters.
module swstat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/swstat_div.sv -----
// Serial signed divider: window sum over held count, truncated toward zero.
// One quotient bit per cycle. Depends on swstat_pkg.
module swstat_div
   import swstat_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_W-1:0]    dividend,
   input  logic        [CNT_W-1:0]    divisor,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic              neg_ff, neg_in;

   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    diff;
   logic              ge;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      diff    = shifted - {1'b0, div_ff};
      ge      = (shifted >= {1'b0, div_ff});
   end

   // Next-value logic for the iteration registers.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         div_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      end else if (busy_ff) begin
         rem_in  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
   end

   // The mean always fits the sample width; restore the sign.
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff[SAMPLE_W-1:0])
                            : $signed(quo_ff[SAMPLE_W-1:0]);

endmodule

// ----- hw/rtl/sliding_window_min_max_mean_unit.sv -----
// Top level of the sliding-window min / max / mean unit: sample RAM, scan
// controller and result register. Depends on swstat_pkg, swstat_ram, swstat_div.
//
//   Channel | Direction | Word
//   req_*   | in        | tdata[31:0] = sample_value
//   rsp_*   | out       | tdata[6:0] valid_count, [38:7] window_mean,
//           |           |   [70:39] window_min, [102:71] window_max, [103] zero
//
// An accepted word is written to the RAM at once; the held entries are then
// read one per cycle through the RAM read port, and the one-bit-per-cycle
// divider then forms the mean. Reset empties the window and the result
// register. A new word is taken while a finished result waits on rsp_tready;
// a stalled result only holds the next one at the final load into the result
// register.
module sliding_window_min_max_mean_unit
   import swstat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [31:0] sample_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // valid_count, mean, min, max, pad
);

   state_type state_ff, state_in;

   logic [IDX_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             pend_ff;
   logic             first_ff, first_in;

   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic signed [SAMPLE_W-1:0] mean_ff;

   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                       accept;
   logic                       rd_en;
   logic                       div_start;
   logic                       load_out;
   logic                       div_done;
   logic signed [SAMPLE_W-1:0] div_quot;
   logic [SAMPLE_W-1:0]        rd_data;
   logic signed [SAMPLE_W-1:0] rd_value;
   logic [CNT_W-1:0]           count_m1;
   logic [IDX_W-1:0]           last_idx;

   assign accept   = req_tvalid && req_tready;
   assign count_m1 = count_ff - 1'b1;
   assign last_idx = count_m1[IDX_W-1:0];
   assign rd_value = $signed(rd_data);

   // Sample store.
   swstat_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Mean divider.
   swstat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_START;
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      div_start  = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_SCAN:  rd_en      = 1'b1;
         ST_START: div_start  = 1'b1;
         ST_PUSH:  load_out   = !rsp_tvalid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Window bookkeeping and scan accumulators.
   always_comb begin
      wp_in    = wp_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      first_in = first_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (accept) begin
         wp_in    = (wp_ff == IDX_W'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;
         count_in = (count_ff == CNT_W'(WINDOW)) ? count_ff : count_ff + 1'b1;
         idx_in   = '0;
         first_in = 1'b1;
         sum_in   = '0;
      end else if (rd_en) begin
         idx_in = idx_ff + 1'b1;
      end
      // Read data arrives in the cycle after its address.
      if (pend_ff) begin
         first_in = 1'b0;
         sum_in   = sum_ff + {{(SUM_W - SAMPLE_W){rd_value[SAMPLE_W-1]}}, rd_value};
         min_in   = (first_ff || rd_value < min_ff) ? rd_value : min_ff;
         max_in   = (first_ff || rd_value > max_ff) ? rd_value : max_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         count_ff <= count_in;
         pend_ff  <= rd_en;
         if (load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      first_ff <= first_in;
      sum_ff   <= sum_in;
      min_ff   <= min_in;
      max_ff   <= max_in;
      if (div_done) begin
         mean_ff <= div_quot;
      end
      if (load_out) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, max_ff, min_ff, mean_ff,
                         COUNT_W'(count_ff)};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- sim/tb_sliding_window_min_max_mean_unit.sv -----
// Self-checking testbench for the sliding-window min / max / mean unit.
// Drives sample words with random bursts, predicts count, mean, min and max,
// and checks every result word. Depends on swstat_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_sliding_window_min_max_mean_unit;
   import swstat_pkg::*;

   // Longest quiet stretch tolerated before the run is declared hung.
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_WORDS  = 900;
   localparam int SETTLE_CYCLES = 150;

   typedef struct {
      logic [COUNT_W-1:0]         count;
      logic signed [SAMPLE_W-1:0] mean;
      logic signed [SAMPLE_W-1:0] min;
      logic signed [SAMPLE_W-1:0] max;
   } window_stats_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;   // [31:0] sample_value
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // valid_count, mean, min, max, pad

   // Predictor state: a private copy of the sample ring.
   logic signed [SAMPLE_W-1:0] ring_samples [WINDOW];
   int                         ring_slot;
   int                         ring_held;

   logic [SAMPLE_W-1:0] pending_samples [$];
   window_stats_type    expected_stats  [$];

   int error_count;
   int burst_left;
   int gap_left;
   int quiet_cycles;
   int pattern_age;
   logic [15:0] ready_pattern;

   sliding_window_min_max_mean_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock generation, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Store one sample in the ring and work out the statistics it leads to.
   function automatic window_stats_type push_sample_get_stats(logic [SAMPLE_W-1:0] sample);
      window_stats_type           stats;
      longint                     total;
      longint                     quotient;
      logic signed [SAMPLE_W-1:0] entry;
      int                         i;
      ring_samples[ring_slot] = sample;
      if (ring_held < WINDOW) ring_held++;
      ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
      total     = 0;
      stats.min = ring_samples[0];
      stats.max = ring_samples[0];
      for (i = 0; i < ring_held; i++) begin
         entry = ring_samples[i];
         total += longint'(entry);
         if (entry < stats.min) stats.min = entry;
         if (entry > stats.max) stats.max = entry;
      end
      // Signed division truncates toward zero, as the mean requires.
      quotient    = total / longint'(ring_held);
      stats.mean  = quotient[SAMPLE_W-1:0];
      stats.count = ring_held[COUNT_W-1:0];
      return stats;
   endfunction

   // Sender: words leave the pending queue in bursts separated by gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left <= $urandom_range(1, 8);
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_stats.push_back(push_sample_get_stats(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_samples.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 8);
                  // Roughly a third of the bursts follow on without a gap.
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready follows a rotating pattern that is replaced now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready    <= 1'b0;
         ready_pattern <= 16'hFFFF;
         pattern_age   <= 0;
      end else begin
         rsp_tready <= ready_pattern[0];
         if (pattern_age == 255) begin
            pattern_age <= 0;
            if ($urandom_range(0, 3) == 0)
               ready_pattern <= 16'hFFFF;
            else
               ready_pattern <= 16'($urandom()) | 16'h0001;
         end else begin
            pattern_age   <= pattern_age + 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
         end
      end
   end

   // Result checker: each accepted word is compared with the oldest prediction.
   always @(posedge clock) begin
      window_stats_type           want;
      logic [COUNT_W-1:0]         got_count;
      logic signed [SAMPLE_W-1:0] got_mean;
      logic signed [SAMPLE_W-1:0] got_min;
      logic signed [SAMPLE_W-1:0] got_max;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_count = rsp_tdata[COUNT_W-1:0];
         got_mean  = rsp_tdata[COUNT_W +: SAMPLE_W];
         got_min   = rsp_tdata[COUNT_W + SAMPLE_W +: SAMPLE_W];
         got_max   = rsp_tdata[COUNT_W + 2 * SAMPLE_W +: SAMPLE_W];
         if (expected_stats.size() == 0) begin
            $error("unexpected result word: valid_count %0d", got_count);
            error_count++;
         end else begin
            want = expected_stats.pop_front();
            if (got_count !== want.count) begin
               $error("valid_count expected %0d got %0d", want.count, got_count);
               error_count++;
            end
            if (got_mean !== want.mean) begin
               $error("window_mean expected %0d got %0d", want.mean, got_mean);
               error_count++;
            end
            if (got_min !== want.min) begin
               $error("window_min expected %0d got %0d", want.min, got_min);
               error_count++;
            end
            if (got_max !== want.max) begin
               $error("window_max expected %0d got %0d", want.max, got_max);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long without any word moving on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_sliding_window_min_max_mean_unit: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int          i;
      int          mode;
      int          run_left;
      logic [31:0] held_value;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      error_count  = 0;
      quiet_cycles = 0;
      ring_slot    = 0;
      ring_held    = 0;
      foreach (ring_samples[k]) ring_samples[k] = '0;

      // Directed: extremes, signs, truncation of negative means, Q16.16 units.
      pending_samples.push_back(32'h7FFF_FFFF);
      pending_samples.push_back(32'h8000_0000);
      pending_samples.push_back(32'h0000_0000);
      pending_samples.push_back(32'hFFFF_FFFF);
      pending_samples.push_back(32'h0000_0001);
      pending_samples.push_back(32'hFFFF_FFFD);
      pending_samples.push_back(32'h8000_0000);
      pending_samples.push_back(32'h8000_0000);
      pending_samples.push_back(32'h7FFF_FFFF);
      pending_samples.push_back(32'h7FFF_FFFF);
      pending_samples.push_back(32'h0001_0000);
      pending_samples.push_back(32'hFFFF_0000);
      pending_samples.push_back(32'h5555_5555);
      pending_samples.push_back(32'hAAAA_AAAA);
      pending_samples.push_back(32'h0000_8000);
      pending_samples.push_back(32'hFFFF_7FFF);

      // Random: runs of differing character; the window fills and wraps early on.
      i = 0;
      while (i < RANDOM_WORDS) begin
         mode       = $urandom_range(0, 4);
         run_left   = $urandom_range(4, 80);
         held_value = $urandom();
         while (run_left > 0 && i < RANDOM_WORDS) begin
            case (mode)
               0: pending_samples.push_back($urandom());
               // Small values around zero exercise truncation of negative means.
               1: pending_samples.push_back(32'($urandom_range(0, 2000)) - 32'd1000);
               2: begin
                  case ($urandom_range(0, 3))
                     0: pending_samples.push_back(32'h7FFF_FFFF);
                     1: pending_samples.push_back(32'h8000_0000);
                     2: pending_samples.push_back(32'h0000_0000);
                     default: pending_samples.push_back(32'hFFFF_FFFF);
                  endcase
               end
               // A constant run makes min, max and mean agree once it fills the ring.
               3: pending_samples.push_back(held_value);
               default: pending_samples.push_back({$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                                   16'($urandom())});
            endcase
            run_left--;
            i++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Drain: every sample taken, then every result seen.
      while (pending_samples.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_stats.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("tb_sliding_window_min_max_mean_unit: PASS");
      else
         $display("tb_sliding_window_min_max_mean_unit: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/swstat_pkg.sv
hw/rtl/swstat_ram.sv
hw/rtl/swstat_div.sv
hw/rtl/sliding_window_min_max_mean_unit.sv
sim/tb_sliding_window_min_max_mean_unit.sv
